// File: design/rgdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgdc_pkg
// shared types, widths and instruction kind codes for the replay group
// drain checker
// ----------------------------------------------------------------------------
package rgdc_pkg;

	// field widths of one request
	localparam int KIND_W  = 4;
	localparam int BASE_W  = 10;
	localparam int COUNT_W = 5;

	// defaults for the top level parameters
	localparam int REG_UNITS_DEF = 1024;
	localparam int MAX_RANGE_DEF = 16;

	// instruction kind codes
	localparam logic [KIND_W-1:0] KIND_NONMEM   = 4'd0;
	localparam logic [KIND_W-1:0] KIND_SCALAR   = 4'd1;
	localparam logic [KIND_W-1:0] KIND_VECTOR   = 4'd2;
	localparam logic [KIND_W-1:0] KIND_TENSOR   = 4'd3;
	localparam logic [KIND_W-1:0] KIND_DRAIN    = 4'd4;
	localparam logic [KIND_W-1:0] KIND_SLEEP    = 4'd5;
	localparam logic [KIND_W-1:0] KIND_PREFETCH = 4'd6;
	localparam logic [KIND_W-1:0] KIND_MSB      = 4'd7;
	localparam logic [KIND_W-1:0] KIND_PSEUDO   = 4'd8;

	// classification flags of the request in the working stage
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              is_atomic;
		logic              is_flat;
		logic              next_is_memory;
	} rgdc_ctrl_t;

	// decision for one request
	typedef struct packed {
		logic drain;
		logic warn;
	} rgdc_result_t;

endpackage

// File: design/rgdc_span_mask.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgdc_span_mask
// turns a base / count register range into a one-hot-per-unit mask,
// wrapping modulo the number of register units
// ----------------------------------------------------------------------------
module rgdc_span_mask #(
	parameter int REG_UNITS = rgdc_pkg::REG_UNITS_DEF,
	parameter int MAX_RANGE = rgdc_pkg::MAX_RANGE_DEF
) (
	input  logic [rgdc_pkg::BASE_W-1:0]  base,
	input  logic [rgdc_pkg::COUNT_W-1:0] count,
	output logic [REG_UNITS-1:0]         mask
);

	localparam int UW = $clog2(REG_UNITS);
	localparam int RW = rgdc_pkg::BASE_W + 1;
	localparam int RED_STEPS = (REG_UNITS >= (1 << rgdc_pkg::BASE_W)) ? 1 :
		$clog2((1 << rgdc_pkg::BASE_W) / REG_UNITS) + 1;

	logic [RW-1:0]                r;
	logic [UW-1:0]                base_r;
	logic [rgdc_pkg::COUNT_W:0]   count_x;
	logic [rgdc_pkg::COUNT_W-1:0] count_sat;

	function automatic logic unit_in_span(input int u, input logic [UW-1:0] b,
			input logic [rgdc_pkg::COUNT_W-1:0] c);
		logic [UW:0] d;
		d = (UW+1)'(u) + (UW+1)'(REG_UNITS) - {1'b0, b};
		if (d >= (UW+1)'(REG_UNITS))
			d = d - (UW+1)'(REG_UNITS);
		return d < (UW+1)'(c);
	endfunction

	// base modulo unit count, restoring steps against shifted constants
	always_comb begin
		r = {1'b0, base};
		for (int k = RED_STEPS - 1; k >= 0; k--) begin
			if (int'(r) >= (REG_UNITS << k))
				r = r - RW'(REG_UNITS << k);
		end
		base_r = UW'(r);
	end

	// count saturation
	always_comb begin
		count_x = {1'b0, count};
		if (count_x > (rgdc_pkg::COUNT_W+1)'(MAX_RANGE))
			count_sat = rgdc_pkg::COUNT_W'(MAX_RANGE);
		else
			count_sat = count;
	end

	always_comb begin
		for (int u = 0; u < REG_UNITS; u++)
			mask[u] = unit_in_span(u, base_r, count_sat);
	end

endmodule

// File: design/rgdc_group_state.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgdc_group_state
// open replay group registers, source unit bitmap and drain decision
// ----------------------------------------------------------------------------
module rgdc_group_state #(
	parameter int REG_UNITS = rgdc_pkg::REG_UNITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   advance,
	input  rgdc_pkg::rgdc_ctrl_t   ctrl,
	input  logic [REG_UNITS-1:0]   dest_mask,
	input  logic [REG_UNITS-1:0]   src_mask,
	output rgdc_pkg::rgdc_result_t result
);

	logic [1:0]           group_type_q;
	logic                 has_mem_q;
	logic                 has_nonatomic_q;
	logic [REG_UNITS-1:0] map_q;

	logic [1:0]           group_type_d;
	logic                 has_mem_d;
	logic                 has_nonatomic_d;
	logic [REG_UNITS-1:0] map_d;

	logic is_scalar, is_vector;
	logic hit_group, hit_own;
	logic clr_type, atom_drain, scal_drain, flat_drain, mem_clear;
	logic hm_a, hn_a, hm_b, hn_b, hm_c, hn_c, hn_d;
	logic violates, exempt;

	assign is_scalar = (ctrl.kind == rgdc_pkg::KIND_SCALAR);
	assign is_vector = (ctrl.kind == rgdc_pkg::KIND_VECTOR);
	assign hit_group = |(dest_mask & map_q);
	assign hit_own   = |(dest_mask & src_mask);

	// memory op rule chain, each drain clears the group
	always_comb begin
		clr_type   = has_mem_q && (group_type_q != ctrl.kind[1:0]);
		hm_a       = has_mem_q & ~clr_type;
		hn_a       = has_nonatomic_q & ~clr_type;
		atom_drain = ctrl.is_atomic && hn_a;
		hm_b       = hm_a & ~atom_drain;
		hn_b       = hn_a & ~atom_drain;
		scal_drain = is_scalar && hm_b && hit_group;
		hm_c       = hm_b & ~scal_drain;
		hn_c       = hn_b & ~scal_drain;
		violates   = is_vector && ctrl.is_flat && hm_c && (hit_group || hit_own);
		exempt     = ctrl.is_atomic && hm_c && !hn_c;
		flat_drain = violates && !exempt;
		hn_d       = hn_c & ~flat_drain;
		mem_clear  = clr_type | atom_drain | scal_drain | flat_drain;
	end

	always_comb begin
		group_type_d    = group_type_q;
		has_mem_d       = has_mem_q;
		has_nonatomic_d = has_nonatomic_q;
		map_d           = map_q;
		result          = '0;
		unique case (ctrl.kind) inside
			rgdc_pkg::KIND_PSEUDO: begin
			end
			rgdc_pkg::KIND_DRAIN: begin
				group_type_d    = '0;
				has_mem_d       = 1'b0;
				has_nonatomic_d = 1'b0;
				map_d           = '0;
			end
			rgdc_pkg::KIND_SLEEP, rgdc_pkg::KIND_PREFETCH: begin
				result.drain    = has_mem_q;
				group_type_d    = '0;
				has_mem_d       = 1'b0;
				has_nonatomic_d = 1'b0;
				map_d           = '0;
			end
			rgdc_pkg::KIND_MSB: begin
				result.drain    = has_mem_q && !ctrl.next_is_memory;
				group_type_d    = '0;
				has_mem_d       = 1'b0;
				has_nonatomic_d = 1'b0;
				map_d           = '0;
			end
			rgdc_pkg::KIND_SCALAR, rgdc_pkg::KIND_VECTOR, rgdc_pkg::KIND_TENSOR: begin
				result.drain    = atom_drain | scal_drain | flat_drain;
				result.warn     = is_scalar && hit_own;
				group_type_d    = ctrl.kind[1:0];
				has_mem_d       = 1'b1;
				has_nonatomic_d = hn_d | ~ctrl.is_atomic;
				map_d           = (mem_clear ? '0 : map_q) | src_mask;
			end
			rgdc_pkg::KIND_NONMEM: begin
				group_type_d    = '0;
				has_mem_d       = 1'b0;
				has_nonatomic_d = 1'b0;
				map_d           = '0;
			end
			default: begin
				group_type_d    = '0;
				has_mem_d       = 1'b0;
				has_nonatomic_d = 1'b0;
				map_d           = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_type_q    <= '0;
			has_mem_q       <= 1'b0;
			has_nonatomic_q <= 1'b0;
			map_q           <= '0;
		end else if (advance) begin
			group_type_q    <= group_type_d;
			has_mem_q       <= has_mem_d;
			has_nonatomic_q <= has_nonatomic_d;
			map_q           <= map_d;
		end
	end

endmodule

// File: design/replay_group_drain_checker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// replay_group_drain_checker_top
// decides per classified instruction whether a full counter drain goes
// in front of it, tracking the open memory replay group
// ----------------------------------------------------------------------------
// usage
//   request channel: req_valid / req_stall plus the instruction fields, a
//     request is taken at a clock edge with req_valid high and req_stall low
//   response channel: rsp_valid / rsp_stall plus drain_before and
//     self_overlap_warning, one response per request, in request order
//   order: a taken request waits in the request register (working stage),
//     and its verdict is written to the response register, raising
//     rsp_valid, at the edge where that stage advances
//   throughput: 1 request per cycle unless rsp_stall holds the flow; all range
//     masks, bitmap overlap tests and the group update sit between the request
//     and response registers, and the group state is written in that same cycle
//   reset (arst_n low): the group is closed, the source unit bitmap is
//     cleared at once and both channels are empty; no clearing pass
//   rsp_stall: the response register holds, the request in the working
//     stage waits without touching the group, and req_stall rises so no
//     further request is taken until the response moves
// ----------------------------------------------------------------------------
module replay_group_drain_checker_top #(
	parameter int REG_UNITS = rgdc_pkg::REG_UNITS_DEF,
	parameter int MAX_RANGE = rgdc_pkg::MAX_RANGE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request channel
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [rgdc_pkg::KIND_W-1:0]   kind,
	input  logic                          is_atomic,
	input  logic                          is_flat,
	input  logic                          next_is_memory,
	input  logic [rgdc_pkg::BASE_W-1:0]   dest_base,
	input  logic [rgdc_pkg::COUNT_W-1:0]  dest_count,
	input  logic [rgdc_pkg::BASE_W-1:0]   src_a_base,
	input  logic [rgdc_pkg::COUNT_W-1:0]  src_a_count,
	input  logic [rgdc_pkg::BASE_W-1:0]   src_b_base,
	input  logic [rgdc_pkg::COUNT_W-1:0]  src_b_count,
	input  logic [rgdc_pkg::BASE_W-1:0]   src_c_base,
	input  logic [rgdc_pkg::COUNT_W-1:0]  src_c_count,
	// response channel
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic                          drain_before,
	output logic                          self_overlap_warning
);

	// request register (working stage)
	logic                         valid_s1;
	rgdc_pkg::rgdc_ctrl_t         ctrl_s1;
	logic [rgdc_pkg::BASE_W-1:0]  dest_base_s1, src_a_base_s1, src_b_base_s1, src_c_base_s1;
	logic [rgdc_pkg::COUNT_W-1:0] dest_count_s1, src_a_count_s1, src_b_count_s1;
	logic [rgdc_pkg::COUNT_W-1:0] src_c_count_s1;

	// response register
	logic                   rsp_valid_q;
	rgdc_pkg::rgdc_result_t result_q;

	rgdc_pkg::rgdc_result_t result;
	logic                   advance;
	logic                   take;
	logic [REG_UNITS-1:0]   dest_mask, src_a_mask, src_b_mask, src_c_mask;

	// the working stage moves on when the response register is free or leaving
	assign advance   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !advance;
	assign take      = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// request payload, no reset needed
	always_ff @(posedge clk) begin
		if (take) begin
			ctrl_s1.kind           <= kind;
			ctrl_s1.is_atomic      <= is_atomic;
			ctrl_s1.is_flat        <= is_flat;
			ctrl_s1.next_is_memory <= next_is_memory;
			dest_base_s1           <= dest_base;
			dest_count_s1          <= dest_count;
			src_a_base_s1          <= src_a_base;
			src_a_count_s1         <= src_a_count;
			src_b_base_s1          <= src_b_base;
			src_b_count_s1         <= src_b_count;
			src_c_base_s1          <= src_c_base;
			src_c_count_s1         <= src_c_count;
		end
	end

	// unit masks for the destination and the three source ranges
	rgdc_span_mask #(.REG_UNITS(REG_UNITS), .MAX_RANGE(MAX_RANGE)) u_dest_mask (
		.base  (dest_base_s1),
		.count (dest_count_s1),
		.mask  (dest_mask)
	);

	rgdc_span_mask #(.REG_UNITS(REG_UNITS), .MAX_RANGE(MAX_RANGE)) u_src_a_mask (
		.base  (src_a_base_s1),
		.count (src_a_count_s1),
		.mask  (src_a_mask)
	);

	rgdc_span_mask #(.REG_UNITS(REG_UNITS), .MAX_RANGE(MAX_RANGE)) u_src_b_mask (
		.base  (src_b_base_s1),
		.count (src_b_count_s1),
		.mask  (src_b_mask)
	);

	rgdc_span_mask #(.REG_UNITS(REG_UNITS), .MAX_RANGE(MAX_RANGE)) u_src_c_mask (
		.base  (src_c_base_s1),
		.count (src_c_count_s1),
		.mask  (src_c_mask)
	);

	// group state only changes when the request leaves the working stage
	rgdc_group_state #(.REG_UNITS(REG_UNITS)) u_group (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.ctrl      (ctrl_s1),
		.dest_mask (dest_mask),
		.src_mask  (src_a_mask | src_b_mask | src_c_mask),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign rsp_valid            = rsp_valid_q;
	assign drain_before         = result_q.drain;
	assign self_overlap_warning = result_q.warn;

endmodule

// File: design/rgdc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgdc_checker
// port level checks on the replay group drain checker, bound to the top
// ----------------------------------------------------------------------------
module rgdc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_stall,
	input logic [rgdc_pkg::KIND_W-1:0] kind,
	input logic                        rsp_valid,
	input logic                        rsp_stall,
	input logic                        drain_before,
	input logic                        self_overlap_warning
);

	// a stalled response holds its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(drain_before) &&
			$stable(self_overlap_warning))
		else $error("stalled response changed");

	// requests flow whenever the response side can take a result
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(!rsp_valid || !rsp_stall) |-> !req_stall)
		else $error("request stalled with free response side");

	// a fresh response comes from a request taken earlier
	a_rsp_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
		else $error("response without matching request");

	// only scalar memory requests can raise the self overlap warning
	a_warn_scalar: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall && (kind != rgdc_pkg::KIND_SCALAR)) ##1
			(!rsp_valid || !rsp_stall) |=> rsp_valid && !self_overlap_warning)
		else $error("overlap warning on non-scalar request");

endmodule

bind replay_group_drain_checker_top rgdc_checker u_rgdc_checker (.*);

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for replay_group_drain_checker_top: a local model of
// the open replay group predicts drain_before and self_overlap_warning for
// every accepted request, and each response is compared in order against it
// ----------------------------------------------------------------------------
module tb;

	localparam int KIND_W      = rgdc_pkg::KIND_W;
	localparam int BASE_W      = rgdc_pkg::BASE_W;
	localparam int COUNT_W     = rgdc_pkg::COUNT_W;
	localparam int REG_UNITS   = rgdc_pkg::REG_UNITS_DEF;
	localparam int MAX_RANGE   = rgdc_pkg::MAX_RANGE_DEF;
	// far above the slowest legal run: ~1600 requests, each at worst a long
	// sender gap plus a long response stall
	localparam int CYCLE_LIMIT = 500000;

	// one classified instruction as the bench sees it
	typedef struct packed {
		logic [KIND_W-1:0]             op;
		logic                          atomic;
		logic                          flat;
		logic                          next_mem;
		logic [BASE_W-1:0]             dst_base;
		logic [COUNT_W-1:0]            dst_cnt;
		logic [2:0][BASE_W-1:0]        src_base;
		logic [2:0][COUNT_W-1:0]       src_cnt;
	} instr_t;

	// clock, reset and every block input start at known values
	logic                clk            = 1'b0;
	logic                arst_n         = 1'b0;
	logic                req_valid      = 1'b0;
	logic                req_stall;
	logic [KIND_W-1:0]   kind           = rgdc_pkg::KIND_NONMEM;
	logic                is_atomic      = 1'b0;
	logic                is_flat        = 1'b0;
	logic                next_is_memory = 1'b0;
	logic [BASE_W-1:0]   dest_base      = '0;
	logic [COUNT_W-1:0]  dest_count     = '0;
	logic [BASE_W-1:0]   src_a_base     = '0;
	logic [COUNT_W-1:0]  src_a_count    = '0;
	logic [BASE_W-1:0]   src_b_base     = '0;
	logic [COUNT_W-1:0]  src_b_count    = '0;
	logic [BASE_W-1:0]   src_c_base     = '0;
	logic [COUNT_W-1:0]  src_c_count    = '0;
	logic                rsp_valid;
	logic                rsp_stall      = 1'b0;
	logic                drain_before;
	logic                self_overlap_warning;

	// bench copy of the replay group
	logic [KIND_W-1:0]   grp_kind;
	bit                  grp_mem;
	bit                  grp_nonatomic;
	bit [REG_UNITS-1:0]  grp_src_map;

	// predicted verdicts waiting for their response, oldest first
	rgdc_pkg::rgdc_result_t pending_verdicts[$];

	// idling knobs, changed per phase
	int                  gap_max   = 0;
	int                  burst_max = 0;
	int                  stall_max = 0;
	int                  burst_left = 0;
	int                  stall_run  = 0;

	// bookkeeping
	int                  errors          = 0;
	int                  requests_sent   = 0;
	int                  directed_sent   = 0;
	int                  verdicts_checked = 0;
	int                  drains_predicted = 0;
	int                  warns_predicted  = 0;
	int                  cycle_count      = 0;

	replay_group_drain_checker_top #(
		.REG_UNITS(REG_UNITS),
		.MAX_RANGE(MAX_RANGE)
	) i_dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.req_valid           (req_valid),
		.req_stall           (req_stall),
		.kind                (kind),
		.is_atomic           (is_atomic),
		.is_flat             (is_flat),
		.next_is_memory      (next_is_memory),
		.dest_base           (dest_base),
		.dest_count          (dest_count),
		.src_a_base          (src_a_base),
		.src_a_count         (src_a_count),
		.src_b_base          (src_b_base),
		.src_b_count         (src_b_count),
		.src_c_base          (src_c_base),
		.src_c_count         (src_c_count),
		.rsp_valid           (rsp_valid),
		.rsp_stall           (rsp_stall),
		.drain_before        (drain_before),
		.self_overlap_warning(self_overlap_warning)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------
	// group model
	// ------------------------------------------------------------------

	// counts above the longest range saturate
	function automatic int clamp_cnt(logic [COUNT_W-1:0] c);
		return (int'(c) > MAX_RANGE) ? MAX_RANGE : int'(c);
	endfunction

	// unit u lies in the wrapping range starting at base
	function automatic bit in_span(int u, int base, int cnt);
		return ((u + REG_UNITS - base) % REG_UNITS) < cnt;
	endfunction

	function automatic void close_group();
		grp_kind      = rgdc_pkg::KIND_NONMEM;
		grp_mem       = 1'b0;
		grp_nonatomic = 1'b0;
		grp_src_map   = '0;
	endfunction

	// destination touches a unit the group has already read
	function automatic bit dest_hits_group(instr_t x);
		for (int i = 0; i < clamp_cnt(x.dst_cnt); i++)
			if (grp_src_map[(int'(x.dst_base) + i) % REG_UNITS])
				return 1'b1;
		return 1'b0;
	endfunction

	// destination touches one of the instruction's own sources
	function automatic bit dest_hits_own(instr_t x);
		int u;
		for (int i = 0; i < clamp_cnt(x.dst_cnt); i++) begin
			u = (int'(x.dst_base) + i) % REG_UNITS;
			for (int k = 0; k < 3; k++)
				if (in_span(u, int'(x.src_base[k]), clamp_cnt(x.src_cnt[k])))
					return 1'b1;
		end
		return 1'b0;
	endfunction

	// verdict for one instruction, updating the group as the block does
	function automatic rgdc_pkg::rgdc_result_t predict_drain(instr_t x);
		rgdc_pkg::rgdc_result_t r;
		bit           violates;
		bit           exempt;
		r = '0;
		case (x.op) inside
			rgdc_pkg::KIND_PSEUDO: begin
			end
			rgdc_pkg::KIND_DRAIN: begin
				close_group();
			end
			rgdc_pkg::KIND_SLEEP, rgdc_pkg::KIND_PREFETCH: begin
				r.drain = grp_mem;
				close_group();
			end
			rgdc_pkg::KIND_MSB: begin
				r.drain = grp_mem && !x.next_mem;
				close_group();
			end
			rgdc_pkg::KIND_SCALAR, rgdc_pkg::KIND_VECTOR, rgdc_pkg::KIND_TENSOR: begin
				// a switch of memory type starts a fresh group
				if (grp_mem && grp_kind != x.op)
					close_group();
				// atomic behind non-atomics
				if (x.atomic && grp_nonatomic) begin
					r.drain = 1'b1;
					close_group();
				end
				if (x.op == rgdc_pkg::KIND_SCALAR) begin
					r.warn = dest_hits_own(x);
					if (grp_mem && dest_hits_group(x)) begin
						r.drain = 1'b1;
						close_group();
					end
				end
				violates = x.op == rgdc_pkg::KIND_VECTOR && x.flat && grp_mem &&
				           (dest_hits_group(x) || dest_hits_own(x));
				exempt   = x.atomic && grp_mem && !grp_nonatomic;
				if (violates && !exempt) begin
					r.drain = 1'b1;
					close_group();
				end
				grp_kind = x.op;
				grp_mem  = 1'b1;
				if (!x.atomic)
					grp_nonatomic = 1'b1;
				for (int k = 0; k < 3; k++)
					for (int i = 0; i < clamp_cnt(x.src_cnt[k]); i++)
						grp_src_map[(int'(x.src_base[k]) + i) % REG_UNITS] = 1'b1;
			end
			default: begin
				// non-memory and unused kind codes
				close_group();
			end
		endcase
		return r;
	endfunction

	// ------------------------------------------------------------------
	// request side
	// ------------------------------------------------------------------

	// drive one request, hold it until taken, then maybe pause the sender;
	// the handshake is judged at the falling edge where all levels are settled
	task automatic send_instr(instr_t x);
		bit           taken;
		int           pause;
		rgdc_pkg::rgdc_result_t v;
		req_valid      <= 1'b1;
		kind           <= x.op;
		is_atomic      <= x.atomic;
		is_flat        <= x.flat;
		next_is_memory <= x.next_mem;
		dest_base      <= x.dst_base;
		dest_count     <= x.dst_cnt;
		src_a_base     <= x.src_base[0];
		src_a_count    <= x.src_cnt[0];
		src_b_base     <= x.src_base[1];
		src_b_count    <= x.src_cnt[1];
		src_c_base     <= x.src_base[2];
		src_c_count    <= x.src_cnt[2];
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !req_stall;
			@(posedge clk);
		end
		v = predict_drain(x);
		pending_verdicts.push_back(v);
		requests_sent++;
		drains_predicted += int'(v.drain);
		warns_predicted  += int'(v.warn);
		// bursts of random length with random gaps between them
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, burst_max);
			pause = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
			if (pause != 0) begin
				req_valid <= 1'b0;
				repeat (pause) @(posedge clk);
			end
		end
	endtask

	function automatic instr_t mk(logic [KIND_W-1:0] op, bit atomic, bit flat, bit next_mem,
	                              int db, int dc, int ab, int ac, int bb, int bc,
	                              int cb, int cc);
		instr_t x;
		x.op          = op;
		x.atomic      = atomic;
		x.flat        = flat;
		x.next_mem    = next_mem;
		x.dst_base    = BASE_W'(db);
		x.dst_cnt     = COUNT_W'(dc);
		x.src_base[0] = BASE_W'(ab);
		x.src_cnt[0]  = COUNT_W'(ac);
		x.src_base[1] = BASE_W'(bb);
		x.src_cnt[1]  = COUNT_W'(bc);
		x.src_base[2] = BASE_W'(cb);
		x.src_cnt[2]  = COUNT_W'(cc);
		return x;
	endfunction

	// range lengths: mostly short, sometimes none, sometimes at or past the cap
	function automatic logic [COUNT_W-1:0] pick_cnt();
		case ($urandom_range(0, 15))
			0:       return '0;
			1:       return COUNT_W'($urandom_range(16, 31));
			default: return COUNT_W'($urandom_range(1, 6));
		endcase
	endfunction

	// memory op with ranges clustered around win so overlaps are common
	function automatic instr_t rand_mem(logic [KIND_W-1:0] op, int win, bit mostly_atomic);
		instr_t x;
		x.op       = op;
		x.atomic   = mostly_atomic ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 3) == 0);
		x.flat     = (op == rgdc_pkg::KIND_VECTOR) ? ($urandom_range(0, 3) != 0) :
		             1'($urandom_range(0, 1));
		x.next_mem = 1'($urandom_range(0, 1));
		x.dst_base = BASE_W'(win + $urandom_range(0, 31));
		x.dst_cnt  = pick_cnt();
		for (int k = 0; k < 3; k++) begin
			x.src_base[k] = BASE_W'(win + $urandom_range(0, 47));
			x.src_cnt[k]  = pick_cnt();
		end
		return x;
	endfunction

	// any bit pattern at all
	function automatic instr_t rand_any();
		instr_t x;
		x.op       = KIND_W'($urandom_range(0, 15));
		x.atomic   = 1'($urandom_range(0, 1));
		x.flat     = 1'($urandom_range(0, 1));
		x.next_mem = 1'($urandom_range(0, 1));
		x.dst_base = BASE_W'($urandom);
		x.dst_cnt  = COUNT_W'($urandom);
		for (int k = 0; k < 3; k++) begin
			x.src_base[k] = BASE_W'($urandom);
			x.src_cnt[k]  = COUNT_W'($urandom);
		end
		return x;
	endfunction

	// ------------------------------------------------------------------
	// response side
	// ------------------------------------------------------------------

	// receiver stall pattern: idle stretches broken by stall runs
	always @(posedge clk) begin
		if (stall_run != 0) begin
			stall_run <= stall_run - 1;
			rsp_stall <= 1'b1;
		end else if (stall_max != 0 && $urandom_range(0, 3) == 0) begin
			stall_run <= $urandom_range(0, stall_max - 1);
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// a response moves at the next rising edge if valid and not stalled now
	always @(negedge clk) begin
		rgdc_pkg::rgdc_result_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_verdicts.size() == 0) begin
				$display("%0t tb: response with no request pending, got drain %0b warn %0b",
				         $time, drain_before, self_overlap_warning);
				errors++;
			end else begin
				want = pending_verdicts.pop_front();
				verdicts_checked++;
				if (drain_before !== want.drain) begin
					$display("%0t tb: drain_before mismatch, expected %0b, got %0b",
					         $time, want.drain, drain_before);
					errors++;
				end
				if (self_overlap_warning !== want.warn) begin
					$display("%0t tb: self_overlap_warning mismatch, expected %0b, got %0b",
					         $time, want.warn, self_overlap_warning);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t tb: timeout with %0d responses outstanding",
			         $time, pending_verdicts.size());
			$display("tb: done, errors");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// hand-built requests through each group rule, field extremes, all kinds
	task automatic test_directed();
		gap_max   = 0;
		burst_max = 0;
		stall_max = 0;
		// open a scalar group reading units 200..203
		send_instr(mk(rgdc_pkg::KIND_SCALAR, 0, 0, 0, 100, 2, 200, 4, 0, 0, 0, 0));
		// scalar dest hits group source, flat ignored on scalar
		send_instr(mk(rgdc_pkg::KIND_SCALAR, 0, 1, 0, 201, 1, 300, 1, 0, 0, 0, 0));
		// atomic behind a non-atomic
		send_instr(mk(rgdc_pkg::KIND_SCALAR, 1, 0, 0, 50, 1, 60, 1, 0, 0, 0, 0));
		// pseudo leaves the group alone
		send_instr(mk(rgdc_pkg::KIND_PSEUDO, 1, 1, 1, 60, 16, 60, 16, 60, 16, 60, 16));
		// forever sleep with memory open, then with nothing open
		send_instr(mk(rgdc_pkg::KIND_SLEEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_instr(mk(rgdc_pkg::KIND_SLEEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		// flat vector with own overlap but no memory yet
		send_instr(mk(rgdc_pkg::KIND_VECTOR, 0, 1, 0, 10, 4, 12, 2, 0, 0, 0, 0));
		// flat vector overlapping its own source in an open group
		send_instr(mk(rgdc_pkg::KIND_VECTOR, 0, 1, 0, 500, 3, 700, 1, 0, 0, 501, 1));
		// flat atomic behind non-atomics
		send_instr(mk(rgdc_pkg::KIND_VECTOR, 1, 1, 0, 800, 2, 810, 2, 0, 0, 0, 0));
		// consecutive atomics exempt the flat overlap
		send_instr(mk(rgdc_pkg::KIND_VECTOR, 1, 1, 0, 810, 1, 0, 0, 810, 1, 0, 0));
		// type switch into tensor, then msb set with memory next
		send_instr(mk(rgdc_pkg::KIND_TENSOR, 0, 0, 1, 0, 16, 0, 16, 16, 16, 32, 16));
		send_instr(mk(rgdc_pkg::KIND_MSB, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0));
		// msb set with no memory next
		send_instr(mk(rgdc_pkg::KIND_TENSOR, 1, 1, 0, 900, 1, 900, 1, 0, 0, 0, 0));
		send_instr(mk(rgdc_pkg::KIND_MSB, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		// ranges wrapping past the last unit, counts above the cap
		send_instr(mk(rgdc_pkg::KIND_SCALAR, 0, 0, 0, 1020, 16, 1023, 31, 1023, 17, 0, 0));
		send_instr(mk(rgdc_pkg::KIND_SCALAR, 0, 0, 0, 5, 1, 0, 0, 0, 0, 0, 0));
		// prefetch closes an open group with a drain
		send_instr(mk(rgdc_pkg::KIND_PREFETCH, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		// full drain: no drain reported, group gone
		send_instr(mk(rgdc_pkg::KIND_VECTOR, 0, 0, 0, 1, 1, 2, 1, 0, 0, 0, 0));
		send_instr(mk(rgdc_pkg::KIND_DRAIN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_instr(mk(rgdc_pkg::KIND_PREFETCH, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		// non-memory and unused codes close the group quietly
		send_instr(mk(rgdc_pkg::KIND_TENSOR, 0, 0, 0, 3, 1, 3, 1, 0, 0, 0, 0));
		send_instr(mk(rgdc_pkg::KIND_NONMEM, 1, 1, 1, 3, 1, 3, 1, 3, 1, 3, 1));
		send_instr(mk(KIND_W'(9), 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		// no destination: no warning even with wide sources
		send_instr(mk(rgdc_pkg::KIND_SCALAR, 0, 0, 0, 7, 0, 0, 31, 0, 31, 0, 31));
		// every field at its all-ones value
		send_instr(mk(KIND_W'(15), 1, 1, 1, 1023, 31, 1023, 31, 1023, 31, 1023, 31));
		directed_sent = requests_sent;
	endtask

	// well-formed groups of one memory type with clustered registers, each
	// followed by a random terminator or run straight into the next group
	task automatic test_group_traffic(int n);
		int               sent;
		int               len;
		int               win;
		bit               mostly_atomic;
		logic [KIND_W-1:0] op;
		instr_t           x;
		sent = 0;
		while (sent < n) begin
			op            = KIND_W'($urandom_range(rgdc_pkg::KIND_SCALAR,
			                                       rgdc_pkg::KIND_TENSOR));
			len           = $urandom_range(1, 6);
			win           = $urandom_range(0, REG_UNITS - 1);
			mostly_atomic = $urandom_range(0, 2) == 0;
			for (int j = 0; j < len; j++) begin
				send_instr(rand_mem(op, win, mostly_atomic));
				sent++;
			end
			x = rand_any();
			case ($urandom_range(0, 9))
				1:       x.op = rgdc_pkg::KIND_NONMEM;
				2:       x.op = rgdc_pkg::KIND_DRAIN;
				3:       x.op = rgdc_pkg::KIND_SLEEP;
				4:       x.op = rgdc_pkg::KIND_PREFETCH;
				5:       x.op = rgdc_pkg::KIND_MSB;
				6:       x.op = rgdc_pkg::KIND_PSEUDO;
				7:       x.op = KIND_W'($urandom_range(9, 15));
				default: x.op = rgdc_pkg::KIND_PSEUDO;
			endcase
			// about a third of groups run straight into the next one
			if ($urandom_range(0, 2) != 0) begin
				send_instr(x);
				sent++;
			end
		end
	endtask

	// unstructured noise across all kinds and full field widths
	task automatic test_noise(int n);
		for (int i = 0; i < n; i++)
			send_instr(rand_any());
	endtask

	// stop sending and wait for every outstanding response
	task automatic wait_drained();
		req_valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		// then wait on to catch any stray response
		repeat (8) @(posedge clk);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();

		// moderate idling on both sides
		gap_max   = 3;
		burst_max = 8;
		stall_max = 4;
		test_group_traffic(420);

		// heavy idling: short bursts, long stalls
		gap_max   = 6;
		burst_max = 2;
		stall_max = 10;
		test_group_traffic(420);

		// back to back, no idling at all
		gap_max   = 0;
		burst_max = 0;
		stall_max = 0;
		test_group_traffic(420);

		gap_max   = 2;
		burst_max = 5;
		stall_max = 3;
		test_noise(300);

		wait_drained();

		$display("tb: %0d requests (%0d hand-built), %0d responses compared",
		         requests_sent, directed_sent, verdicts_checked);
		$display("tb: %0d drains and %0d self-overlap warnings predicted, %0d mismatches",
		         drains_predicted, warns_predicted, errors);
		if (errors == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule
